// File: rtl/pcsv_pkg.sv
// Package with shared constants, fault codes and the CRC-32 byte update for the PNG validator.
`timescale 1ns / 1ps

package pcsv_pkg;

  // Fault codes reported with each verdict.
  typedef logic [3:0] fault_t;

  localparam fault_t FAULT_NONE      = 4'd0;
  localparam fault_t FAULT_SIGNATURE = 4'd1;
  localparam fault_t FAULT_TRUNCATED = 4'd2;
  localparam fault_t FAULT_CRC       = 4'd3;
  localparam fault_t FAULT_HEADER    = 4'd4;
  localparam fault_t FAULT_SPLIT     = 4'd5;
  localparam fault_t FAULT_CRITICAL  = 4'd6;
  localparam fault_t FAULT_BAD_END   = 4'd7;
  localparam fault_t FAULT_TRAILING  = 4'd8;

  // Configuration register indexes.
  localparam logic CFG_REG_WIDTH  = 1'b0;
  localparam logic CFG_REG_HEIGHT = 1'b1;

  // Chunk type words, big-endian ASCII.
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam logic [5:0]  MIN_FILE_BYTES = 6'd57;
  localparam logic [31:0] HEADER_BYTES   = 32'd13;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // One byte of the fixed 8-byte file signature.
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // Reflected CRC-32 update over one byte, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/pcsv_stream_if.sv
// Stream interfaces for the byte input channel and the verdict output channel.
`timescale 1ns / 1ps

interface pcsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcsv_out_if;
  logic                valid;
  logic                ready;
  logic                accepted;
  pcsv_pkg::fault_t    fault_code;

  modport source (output valid, output accepted, output fault_code, input ready);
  modport sink   (input valid, input accepted, input fault_code, output ready);
endinterface

// File: rtl/png_chunk_stream_validator.sv
// Top level of the PNG chunk stream validator: byte parser, CRC check and verdict output.
//
//   channel  | dir | payload                           | notes
//   ---------+-----+-----------------------------------+------------------------------
//   in_ch    | in  | data_byte[7:0], last_byte         | one file byte per request
//   out_ch   | out | accepted, fault_code[3:0]         | one verdict per file
//   cfg_*    | in  | cfg_we, cfg_index, cfg_data[31:0] | expected width / height
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle is sustained.
// The verdict for a file is registered when its last byte is accepted, into the result
// register or, if that is full, into one skid entry; these part the two sides, so input only
// stalls when two verdicts are waiting. Reset (rst_n low, synchronous) clears the parser
// and restores the expected width to 1280 and height to 800.
`timescale 1ns / 1ps

module png_chunk_stream_validator (
  input  logic              clk,
  input  logic              rst_n,
  pcsv_in_if.sink           in_ch,
  pcsv_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  // Parser phases.
  localparam logic [2:0] PH_SIGNATURE = 3'd0;
  localparam logic [2:0] PH_LENGTH    = 3'd1;
  localparam logic [2:0] PH_TYPE      = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_CRC       = 3'd4;
  localparam logic [2:0] PH_AFTER_END = 3'd5;
  localparam logic [2:0] PH_HALTED    = 3'd6;

  logic [31:0] exp_width_r;
  logic [31:0] exp_height_r;

  logic [2:0]       phase_r,    phase_nxt;
  logic [31:0]      idx_r,      idx_nxt;
  logic [31:0]      len_r,      len_nxt;
  logic [31:0]      type_r,     type_nxt;
  logic [31:0]      crc_r,      crc_nxt;
  logic [31:0]      rcrc_r,     rcrc_nxt;
  logic [31:0]      hword_r,    hword_nxt;
  logic             first_r,    first_nxt;
  logic             idat_seen_r, idat_seen_nxt;
  logic             idat_closed_r, idat_closed_nxt;
  pcsv_pkg::fault_t pending_r,  pending_nxt;
  pcsv_pkg::fault_t latched_r,  latched_nxt;
  logic [5:0]       count_r,    count_nxt;

  logic             out_valid_r;
  logic             out_acc_r;
  pcsv_pkg::fault_t out_code_r;
  logic             skid_valid_r;
  logic             skid_acc_r;
  pcsv_pkg::fault_t skid_code_r;

  logic             in_fire;
  logic             push;
  logic             pop;
  pcsv_pkg::fault_t verdict_code;
  logic [7:0]       b;
  logic [31:0]      type_new;
  logic [31:0]      rcrc_new;
  logic [31:0]      hword_new;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = in_fire && in_ch.last_byte;
  assign pop         = out_valid_r && out_ch.ready;

  assign b         = in_ch.data_byte;
  assign type_new  = {type_r[23:0], b};
  assign rcrc_new  = {rcrc_r[23:0], b};
  assign hword_new = {hword_r[23:0], b};

  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.fault_code = out_code_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= 32'd1280;
      exp_height_r <= 32'd800;
    end else if (cfg_we) begin
      case (cfg_index)
        pcsv_pkg::CFG_REG_WIDTH:  exp_width_r  <= cfg_data;
        pcsv_pkg::CFG_REG_HEIGHT: exp_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next parser state for the accepted byte, the verdict, and the restart after it.
  always_comb begin
    phase_nxt       = phase_r;
    idx_nxt         = idx_r;
    len_nxt         = len_r;
    type_nxt        = type_r;
    crc_nxt         = crc_r;
    rcrc_nxt        = rcrc_r;
    hword_nxt       = hword_r;
    first_nxt       = first_r;
    idat_seen_nxt   = idat_seen_r;
    idat_closed_nxt = idat_closed_r;
    pending_nxt     = pending_r;
    latched_nxt     = latched_r;
    count_nxt       = count_r;

    if (in_fire) begin
      if (count_r < pcsv_pkg::MIN_FILE_BYTES) begin
        count_nxt = count_r + 6'd1;
      end

      case (phase_r)
        PH_SIGNATURE: begin
          if (b != pcsv_pkg::sig_byte(idx_r[2:0])) begin
            latched_nxt = pcsv_pkg::FAULT_SIGNATURE;
            phase_nxt   = PH_HALTED;
          end else if (idx_r >= 32'd7) begin
            idx_nxt   = 32'd0;
            phase_nxt = PH_LENGTH;
          end else begin
            idx_nxt = idx_r + 32'd1;
          end
        end

        PH_LENGTH: begin
          len_nxt = {len_r[23:0], b};
          if (idx_r >= 32'd3) begin
            idx_nxt     = 32'd0;
            type_nxt    = 32'd0;
            crc_nxt     = '1;
            pending_nxt = pcsv_pkg::FAULT_NONE;
            hword_nxt   = 32'd0;
            phase_nxt   = PH_TYPE;
          end else begin
            idx_nxt = idx_r + 32'd1;
          end
        end

        PH_TYPE: begin
          crc_nxt  = pcsv_pkg::crc_byte(crc_r, b);
          type_nxt = type_new;
          if (idx_r >= 32'd3) begin
            // Chunk ordering and type rules, held pending until the CRC is known.
            if (first_r) begin
              if (len_r != pcsv_pkg::HEADER_BYTES || type_new != pcsv_pkg::TYPE_IHDR) begin
                if (pending_r == pcsv_pkg::FAULT_NONE) pending_nxt = pcsv_pkg::FAULT_HEADER;
              end
            end else if (type_new == pcsv_pkg::TYPE_IDAT) begin
              if (idat_closed_r && pending_r == pcsv_pkg::FAULT_NONE) begin
                pending_nxt = pcsv_pkg::FAULT_SPLIT;
              end
              idat_seen_nxt = 1'b1;
            end else if (type_new == pcsv_pkg::TYPE_IEND) begin
              if ((!idat_seen_r || len_r != 32'd0) && pending_r == pcsv_pkg::FAULT_NONE) begin
                pending_nxt = pcsv_pkg::FAULT_BAD_END;
              end
            end else begin
              if (idat_seen_r) idat_closed_nxt = 1'b1;
              if ((type_new[31:24] inside {[8'h41:8'h5A]}) &&
                  pending_r == pcsv_pkg::FAULT_NONE) begin
                pending_nxt = pcsv_pkg::FAULT_CRITICAL;
              end
            end
            idx_nxt   = 32'd0;
            phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
          end else begin
            idx_nxt = idx_r + 32'd1;
          end
        end

        PH_DATA: begin
          crc_nxt = pcsv_pkg::crc_byte(crc_r, b);
          // Header field checks while the first chunk is still clean.
          if (first_r && pending_r == pcsv_pkg::FAULT_NONE) begin
            hword_nxt = hword_new;
            if (idx_r == 32'd3) begin
              if (hword_new != exp_width_r) pending_nxt = pcsv_pkg::FAULT_HEADER;
            end else if (idx_r == 32'd7) begin
              if (hword_new != exp_height_r) pending_nxt = pcsv_pkg::FAULT_HEADER;
            end else if (idx_r == 32'd8) begin
              if (b != 8'd8) pending_nxt = pcsv_pkg::FAULT_HEADER;
            end else if (idx_r == 32'd9) begin
              if (b != 8'd6) pending_nxt = pcsv_pkg::FAULT_HEADER;
            end else if (idx_r >= 32'd10 && idx_r <= 32'd12) begin
              if (b != 8'd0) pending_nxt = pcsv_pkg::FAULT_HEADER;
            end
          end
          if (({1'b0, idx_r} + 33'd1) >= {1'b0, len_r}) begin
            idx_nxt   = 32'd0;
            rcrc_nxt  = 32'd0;
            phase_nxt = PH_CRC;
          end else begin
            idx_nxt = idx_r + 32'd1;
          end
        end

        PH_CRC: begin
          rcrc_nxt = rcrc_new;
          if (idx_r < 32'd3) begin
            idx_nxt = idx_r + 32'd1;
          end else begin
            idx_nxt = 32'd0;
            // A CRC mismatch outranks any content fault of the same chunk.
            if (~crc_r != rcrc_new) begin
              latched_nxt = pcsv_pkg::FAULT_CRC;
              phase_nxt   = PH_HALTED;
            end else if (pending_r != pcsv_pkg::FAULT_NONE) begin
              latched_nxt = pending_r;
              phase_nxt   = PH_HALTED;
            end else begin
              first_nxt = 1'b0;
              len_nxt   = 32'd0;
              phase_nxt = (type_r == pcsv_pkg::TYPE_IEND) ? PH_AFTER_END : PH_LENGTH;
            end
          end
        end

        PH_AFTER_END: begin
          latched_nxt = pcsv_pkg::FAULT_TRAILING;
          phase_nxt   = PH_HALTED;
        end

        default: ;
      endcase
    end

    // Verdict from the state after this byte.
    if (latched_nxt != pcsv_pkg::FAULT_NONE) begin
      verdict_code = latched_nxt;
    end else if (count_nxt < pcsv_pkg::MIN_FILE_BYTES || phase_nxt != PH_AFTER_END) begin
      verdict_code = pcsv_pkg::FAULT_TRUNCATED;
    end else begin
      verdict_code = pcsv_pkg::FAULT_NONE;
    end

    // The last byte ends the file; the next byte starts a new one.
    if (push) begin
      phase_nxt       = PH_SIGNATURE;
      idx_nxt         = 32'd0;
      len_nxt         = 32'd0;
      type_nxt        = 32'd0;
      crc_nxt         = '1;
      rcrc_nxt        = 32'd0;
      hword_nxt       = 32'd0;
      first_nxt       = 1'b1;
      idat_seen_nxt   = 1'b0;
      idat_closed_nxt = 1'b0;
      pending_nxt     = pcsv_pkg::FAULT_NONE;
      latched_nxt     = pcsv_pkg::FAULT_NONE;
      count_nxt       = 6'd0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIGNATURE;
      idx_r         <= 32'd0;
      len_r         <= 32'd0;
      type_r        <= 32'd0;
      crc_r         <= '1;
      rcrc_r        <= 32'd0;
      hword_r       <= 32'd0;
      first_r       <= 1'b1;
      idat_seen_r   <= 1'b0;
      idat_closed_r <= 1'b0;
      pending_r     <= pcsv_pkg::FAULT_NONE;
      latched_r     <= pcsv_pkg::FAULT_NONE;
      count_r       <= 6'd0;
    end else begin
      phase_r       <= phase_nxt;
      idx_r         <= idx_nxt;
      len_r         <= len_nxt;
      type_r        <= type_nxt;
      crc_r         <= crc_nxt;
      rcrc_r        <= rcrc_nxt;
      hword_r       <= hword_nxt;
      first_r       <= first_nxt;
      idat_seen_r   <= idat_seen_nxt;
      idat_closed_r <= idat_closed_nxt;
      pending_r     <= pending_nxt;
      latched_r     <= latched_nxt;
      count_r       <= count_nxt;
    end
  end

  // Result register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_acc_r    <= skid_acc_r;
        out_code_r   <= skid_code_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
        out_acc_r   <= (verdict_code == pcsv_pkg::FAULT_NONE);
        out_code_r  <= verdict_code;
      end else begin
        skid_valid_r <= 1'b1;
        skid_acc_r   <= (verdict_code == pcsv_pkg::FAULT_NONE);
        skid_code_r  <= verdict_code;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // The skid entry is only ever used behind a full result register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a verdict while the result register is empty");

  // A shown verdict is accepted exactly when it carries no fault.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_acc_r == (out_code_r == pcsv_pkg::FAULT_NONE)))
    else $error("accepted flag disagrees with fault code");

  // The parser halts exactly when a fault has been latched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALTED) == (latched_r != pcsv_pkg::FAULT_NONE))
    else $error("halted phase and latched fault disagree");

  // The last byte of a file restarts the parser.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (phase_r == PH_SIGNATURE && count_r == 6'd0 && first_r))
    else $error("parser did not restart after the last byte");

  // A pending content fault only exists after a chunk's type has been read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != pcsv_pkg::FAULT_NONE) |->
      (phase_r == PH_DATA || phase_r == PH_CRC || phase_r == PH_HALTED))
    else $error("pending fault outside a chunk body");

endmodule
